[hw/rtl/ps2md_pkg.sv]
package ps2md_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OUT_POS_W = 12;
    localparam int unsigned BTN_W     = 3;
    localparam int unsigned DX_W      = 9;
    localparam int unsigned DY_W      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS_Y = 2'd1;

    localparam logic [CFG_W-1:0] MAX_POS_X_RESET = 12'd1280;
    localparam logic [CFG_W-1:0] MAX_POS_Y_RESET = 12'd780;

    // head byte bit positions
    localparam int unsigned HEAD_SYNC_BIT  = 3;
    localparam int unsigned HEAD_XSIGN_BIT = 4;
    localparam int unsigned HEAD_YSIGN_BIT = 5;
    localparam int unsigned HEAD_XOVF_BIT  = 6;
    localparam int unsigned HEAD_YOVF_BIT  = 7;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_X    = 2'd1,
        PH_Y    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
    } t_packet;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

[hw/rtl/ps2md_front.sv]
module ps2md_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [7:0]                i_rx_byte,
    input  logic                      i_q_full,
    output logic                      o_full,
    output logic                      o_q_push,
    output ps2md_pkg::t_packet        o_q_data
);
    import ps2md_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_head, n_head;
    logic [BYTE_W-1:0] r_xb, n_xb;
    logic              accept;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_head  = r_head;
        n_xb    = r_xb;
        if (accept) begin
            unique case (r_phase)
                PH_X: begin
                    n_xb    = i_rx_byte;
                    n_phase = PH_Y;
                end
                PH_Y: begin
                    n_phase = PH_HEAD;
                end
                default: begin
                    n_head  = i_rx_byte;
                    n_phase = i_rx_byte[HEAD_SYNC_BIT] ? PH_X : PH_HEAD;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_q_push      = 1'b0;
        o_q_data.head = r_head;
        o_q_data.x    = r_xb;
        o_q_data.y    = i_rx_byte;
        unique case (r_phase)
            PH_Y:    o_q_push = accept;
            default: o_q_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_head  <= '0;
            r_xb    <= '0;
        end else begin
            r_phase <= n_phase;
            r_head  <= n_head;
            r_xb    <= n_xb;
        end
    end

endmodule

[hw/rtl/ps2md_fifo.sv]
module ps2md_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ps2md_pkg::t_packet   i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output ps2md_pkg::t_packet   o_data
);
    import ps2md_pkg::*;

    t_packet              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic                 do_wr, do_rd;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/ps2md_back.sv]
module ps2md_back #(
    parameter int unsigned POS_WIDTH = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ps2md_pkg::t_cfg_wr    i_cfg,
    input  logic                  i_q_empty,
    input  ps2md_pkg::t_packet    i_q_data,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic signed [8:0]     o_delta_x,
    output logic signed [9:0]     o_delta_y,
    output logic [11:0]           o_pos_x,
    output logic [11:0]           o_pos_y,
    output logic [2:0]            o_button_bits,
    output logic                  o_moved,
    output logic                  o_buttons_changed,
    output logic                  o_overflowed
);
    import ps2md_pkg::*;

    localparam int unsigned SUM_W = POS_WIDTH + 2;

    logic [CFG_W-1:0]         r_max_x, r_max_y;
    logic [POS_WIDTH-1:0]     r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    logic [BTN_W-1:0]         r_last_btn;
    logic                     r_out_valid, n_out_valid;

    logic signed [DX_W-1:0]   r_dx;
    logic signed [DY_W-1:0]   r_dy;
    logic [BTN_W-1:0]         r_btn;
    logic                     r_moved, r_changed, r_ovf;

    logic                     take;
    logic                     ovf, moved;
    logic signed [DX_W-1:0]   dx_raw, dy_raw, dx;
    logic signed [DY_W-1:0]   dy;
    logic [BTN_W-1:0]         btn;
    logic [SUM_W-1:0]         lim_x, lim_y;
    logic signed [SUM_W-1:0]  sum_x, sum_y;

    function automatic logic [POS_WIDTH-1:0] clamp(
        input logic signed [SUM_W-1:0] s,
        input logic [SUM_W-1:0]        lim
    );
        logic [SUM_W-1:0] v;
        begin
            if (s < 0) begin
                v = '0;
            end else if (s > $signed(lim)) begin
                v = lim;
            end else begin
                v = s;
            end
            clamp = v[POS_WIDTH-1:0];
        end
    endfunction

    // cursor limit seen in cursor width
    generate
        if (POS_WIDTH >= CFG_W) begin : g_lim_wide
            assign lim_x = SUM_W'(r_max_x);
            assign lim_y = SUM_W'(r_max_y);
        end else begin : g_lim_narrow
            assign lim_x = SUM_W'(r_max_x[POS_WIDTH-1:0]);
            assign lim_y = SUM_W'(r_max_y[POS_WIDTH-1:0]);
        end
    endgenerate

    assign take    = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = take;
    assign o_empty = !r_out_valid;

    always_comb begin
        dx_raw = $signed({i_q_data.head[HEAD_XSIGN_BIT], i_q_data.x});
        dy_raw = $signed({i_q_data.head[HEAD_YSIGN_BIT], i_q_data.y});
        ovf    = i_q_data.head[HEAD_XOVF_BIT] | i_q_data.head[HEAD_YOVF_BIT];
        dx     = ovf ? '0 : dx_raw;
        dy     = ovf ? '0 : -DY_W'(dy_raw);
        moved  = (dx != '0) || (dy != '0);
        btn    = i_q_data.head[BTN_W-1:0];
        sum_x  = $signed(SUM_W'(r_cur_x)) + SUM_W'(dx);
        sum_y  = $signed(SUM_W'(r_cur_y)) + SUM_W'(dy);
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (moved) begin
            n_cur_x = clamp(sum_x, lim_x);
            n_cur_y = clamp(sum_y, lim_y);
        end
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x     <= MAX_POS_X_RESET;
            r_max_y     <= MAX_POS_Y_RESET;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_last_btn  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.we && i_cfg.idx == CFG_MAX_POS_X) begin
                r_max_x <= i_cfg.data;
            end else if (i_cfg.we && i_cfg.idx == CFG_MAX_POS_Y) begin
                r_max_y <= i_cfg.data;
            end
            if (take) begin
                r_cur_x    <= n_cur_x;
                r_cur_y    <= n_cur_y;
                r_last_btn <= btn;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dx      <= dx;
            r_dy      <= dy;
            r_btn     <= btn;
            r_moved   <= moved;
            r_changed <= (btn != r_last_btn);
            r_ovf     <= ovf;
        end
    end

    assign o_delta_x         = r_dx;
    assign o_delta_y         = r_dy;
    assign o_pos_x           = OUT_POS_W'(r_cur_x);
    assign o_pos_y           = OUT_POS_W'(r_cur_y);
    assign o_button_bits     = r_btn;
    assign o_moved           = r_moved;
    assign o_buttons_changed = r_changed;
    assign o_overflowed      = r_ovf;

endmodule

[hw/rtl/ps2_mouse_packet_decoder.sv]
// Decodes the byte stream of a three-byte PS/2 mouse into one word per packet.
// Bytes are pushed one per clock while full is low, with no gaps needed
// between packets; a byte with bit 3 clear while a head byte is expected is
// dropped to regain packet sync. The third byte of a packet produces a word
// holding the 9-bit X and 10-bit Y deltas (zero on overflow, Y negated to
// screen direction), the cursor position clamped to 0..max_pos_x/max_pos_y,
// the buttons and the moved, buttons-changed and overflow flags. The cursor
// moves only on a nonzero move, so a lowered maximum takes effect at the next
// move. A word passes through the two-entry packet queue and then the one-word
// output register before it can be popped; these let input continue while
// results wait, and full rises only when both are occupied. Write max_pos_x
// (index 0) and max_pos_y (index 1) only while no packet is in flight.
module ps2_mouse_packet_decoder #(
    parameter int unsigned POS_WIDTH = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [11:0]          i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_rx_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [8:0]    o_delta_x,
    output logic signed [9:0]    o_delta_y,
    output logic [11:0]          o_pos_x,
    output logic [11:0]          o_pos_y,
    output logic [2:0]           o_button_bits,
    output logic                 o_moved,
    output logic                 o_buttons_changed,
    output logic                 o_overflowed
);
    import ps2md_pkg::*;

    t_cfg_wr cfg;
    t_packet q_wr_data, q_rd_data;
    logic    q_push, q_full, q_pop, q_empty;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    ps2md_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_q_data  (q_wr_data)
    );

    ps2md_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    ps2md_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_q_empty         (q_empty),
        .i_q_data          (q_rd_data),
        .o_q_pop           (q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_delta_x         (o_delta_x),
        .o_delta_y         (o_delta_y),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y),
        .o_button_bits     (o_button_bits),
        .o_moved           (o_moved),
        .o_buttons_changed (o_buttons_changed),
        .o_overflowed      (o_overflowed)
    );

endmodule
